>>> hdl/rsa_pkg.sv
package rsa_pkg;

  // Sizes of the value table and the slot pool.
  localparam int VALUE_COUNT = 256;
  localparam int SLOT_COUNT  = 64;

  // Field widths of the stream words.
  localparam int CMD_W  = 2;
  localparam int VAL_W  = $clog2(VALUE_COUNT);
  localparam int CNT_W  = 8;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int MADE_W = SLOT_W + 1;
  localparam int STAT_W = 2;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 1 + STAT_W;

  // Request codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_USE     = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_LIVE      = 2'd1,
    ST_DEAD      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  // One entry of the value table: the slot held and the reads still due.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  uses;
  } rsa_entry_t;

  // Write into the value table.
  typedef struct packed {
    logic              en;
    logic [VAL_W-1:0]  addr;
    rsa_entry_t        entry;
  } rsa_tbl_wr_t;

  // Lookup result of the value table.
  typedef struct packed {
    logic       live;
    rsa_entry_t entry;
  } rsa_tbl_look_t;

  // Operation on the free stack.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [SLOT_W-1:0] push_slot;
  } rsa_stk_op_t;

  // State of the free stack seen by the control logic.
  typedef struct packed {
    logic [MADE_W-1:0] count;
    logic [SLOT_W-1:0] top;
  } rsa_stk_stat_t;

endpackage

>>> hdl/rsa_value_table.sv
module rsa_value_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [rsa_pkg::VAL_W-1:0]   rd_addr,
  input  logic [rsa_pkg::VAL_W-1:0]   lk_addr,
  input  rsa_pkg::rsa_tbl_wr_t        wr,
  input  logic                        clr,
  output rsa_pkg::rsa_tbl_look_t      look
);

  rsa_pkg::rsa_entry_t mem_r [rsa_pkg::VALUE_COUNT];
  rsa_pkg::rsa_entry_t rd_data_r;
  logic [rsa_pkg::VALUE_COUNT-1:0] valid_r;
  logic                            byp_en_r;
  logic [rsa_pkg::VAL_W-1:0]       byp_addr_r;
  rsa_pkg::rsa_entry_t             byp_data_r;
  rsa_pkg::rsa_entry_t             entry;

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Valid bits stand for the all-zero reset of the reference counts.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // The last write is kept so a read issued in the same cycle sees it.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      byp_en_r <= 1'b0;
    end else if (wr.en) begin
      byp_en_r <= 1'b1;
    end
    if (wr.en) begin
      byp_addr_r <= wr.addr;
      byp_data_r <= wr.entry;
    end
  end

  // Lookup with bypass; an entry never written reads as dead.
  always_comb begin
    entry      = (byp_en_r && byp_addr_r == lk_addr) ? byp_data_r : rd_data_r;
    look.entry = entry;
    look.live  = valid_r[lk_addr] && (entry.uses != '0);
  end

endmodule

>>> hdl/rsa_free_stack.sv
module rsa_free_stack (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rsa_pkg::rsa_stk_op_t   op,
  output rsa_pkg::rsa_stk_stat_t stat
);

  logic [rsa_pkg::SLOT_W-1:0] mem_r [rsa_pkg::SLOT_COUNT];
  logic [rsa_pkg::MADE_W-1:0] count_r;
  logic [rsa_pkg::MADE_W-1:0] count_nxt;
  logic [rsa_pkg::MADE_W-1:0] pre_addr;
  logic [rsa_pkg::SLOT_W-1:0] top_r;
  logic [rsa_pkg::SLOT_W-1:0] sec_r;
  logic [rsa_pkg::SLOT_W-1:0] pre_r;
  logic                       do_push;

  // A push onto a full stack is dropped.
  assign do_push = op.push && (count_r < rsa_pkg::MADE_W'(rsa_pkg::SLOT_COUNT));

  // Next depth of the stack.
  always_comb begin
    count_nxt = count_r;
    if (op.clear) begin
      count_nxt = '0;
    end else if (do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (op.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // The third entry from the top is prefetched for the next pop.
  assign pre_addr = count_nxt - rsa_pkg::MADE_W'(3);

  // Stack memory: every pushed slot lands at the current depth.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[count_r[rsa_pkg::SLOT_W-1:0]] <= op.push_slot;
    end
    pre_r <= mem_r[pre_addr[rsa_pkg::SLOT_W-1:0]];
  end

  // Depth counter and the two top entries held in registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    if (!op.clear) begin
      if (do_push) begin
        top_r <= op.push_slot;
        sec_r <= top_r;
      end else if (op.pop) begin
        top_r <= sec_r;
        sec_r <= pre_r;
      end
    end
  end

  assign stat.count = count_r;
  assign stat.top   = top_r;

endmodule

>>> hdl/refcounted_slot_allocator_unit.sv
// A taken request goes to the input register, its result word to the result register.
// Throughput: one request per cycle; the value table read, registered at
// acceptance, and the free stack with its prefetched entries keep pace.
// Back pressure on the result side stalls the execute stage and input.
// Reset (rst_n low at a clock edge) empties the pipeline, the free stack and
// the slot count, and marks every value dead at once; no clearing pass.
module refcounted_slot_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rsa_pkg::IN_DATA_W-1:0]     in_tdata,  // value_id, consumer_count
  input  logic [rsa_pkg::CMD_W-1:0]         in_tuser,  // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rsa_pkg::OUT_DATA_W-1:0]    out_tdata, // slot, slots_used, zero pad
  output logic [rsa_pkg::OUT_USER_W-1:0]    out_tuser  // released, status
);

  logic                        s1_valid_r;
  logic [rsa_pkg::CMD_W-1:0]   s1_cmd_r;
  logic [rsa_pkg::VAL_W-1:0]   s1_val_r;
  logic [rsa_pkg::CNT_W-1:0]   s1_cnt_r;
  logic [rsa_pkg::MADE_W-1:0]  made_r;
  logic [rsa_pkg::MADE_W-1:0]  made_nxt;
  logic                        out_valid_r;
  logic [rsa_pkg::SLOT_W-1:0]  out_slot_r;
  logic                        out_rel_r;
  logic [rsa_pkg::MADE_W-1:0]  out_used_r;
  rsa_pkg::status_t            out_status_r;
  logic                        advance;
  logic                        accept;
  logic [rsa_pkg::SLOT_W-1:0]  res_slot;
  logic                        res_rel;
  rsa_pkg::status_t            res_status;
  logic                        tbl_clr;
  rsa_pkg::rsa_tbl_wr_t        tbl_wr;
  rsa_pkg::rsa_tbl_look_t      tbl_look;
  rsa_pkg::rsa_stk_op_t        stk_op;
  rsa_pkg::rsa_stk_stat_t      stk_stat;

  // Handshake: the execute stage moves when the result register is free.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (accept) begin
      s1_cmd_r <= in_tuser;
      s1_val_r <= in_tdata[rsa_pkg::VAL_W-1:0];
      s1_cnt_r <= in_tdata[rsa_pkg::VAL_W +: rsa_pkg::CNT_W];
    end
  end

  rsa_value_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_tdata[rsa_pkg::VAL_W-1:0]),
    .lk_addr (s1_val_r),
    .wr      (tbl_wr),
    .clr     (tbl_clr),
    .look    (tbl_look)
  );

  rsa_free_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (stk_op),
    .stat  (stk_stat)
  );

  // Request execution.
  always_comb begin
    res_slot   = '0;
    res_rel    = 1'b0;
    res_status = rsa_pkg::ST_OK;
    made_nxt   = made_r;
    tbl_clr    = 1'b0;
    tbl_wr     = '0;
    stk_op     = '0;
    tbl_wr.addr = s1_val_r;
    case (rsa_pkg::cmd_t'(s1_cmd_r))
      rsa_pkg::CMD_RESTART: begin
        tbl_clr      = 1'b1;
        stk_op.clear = 1'b1;
        made_nxt     = '0;
      end
      rsa_pkg::CMD_ALLOC: begin
        if (tbl_look.live) begin
          res_slot   = tbl_look.entry.slot;
          res_status = rsa_pkg::ST_LIVE;
        end else if (stk_stat.count == '0 &&
                     made_r >= rsa_pkg::MADE_W'(rsa_pkg::SLOT_COUNT)) begin
          res_status = rsa_pkg::ST_EXHAUSTED;
        end else begin
          res_slot = (stk_stat.count != '0) ? stk_stat.top
                                            : made_r[rsa_pkg::SLOT_W-1:0];
          if (s1_cnt_r == '0) begin
            // A value with no readers dies at once and takes nothing.
            res_rel = 1'b1;
          end else begin
            if (stk_stat.count != '0) begin
              stk_op.pop = 1'b1;
            end else begin
              made_nxt = made_r + 1'b1;
            end
            tbl_wr.en         = 1'b1;
            tbl_wr.entry.slot = res_slot;
            tbl_wr.entry.uses = s1_cnt_r;
          end
        end
      end
      rsa_pkg::CMD_USE: begin
        if (!tbl_look.live) begin
          res_status = rsa_pkg::ST_DEAD;
        end else begin
          res_slot          = tbl_look.entry.slot;
          tbl_wr.en         = 1'b1;
          tbl_wr.entry.slot = tbl_look.entry.slot;
          tbl_wr.entry.uses = tbl_look.entry.uses - 1'b1;
          if (tbl_look.entry.uses == rsa_pkg::CNT_W'(1)) begin
            // Last read: the slot goes back onto the free stack.
            res_rel          = 1'b1;
            stk_op.push      = 1'b1;
            stk_op.push_slot = tbl_look.entry.slot;
          end
        end
      end
      default: begin
      end
    endcase
    if (!advance) begin
      tbl_clr   = 1'b0;
      tbl_wr.en = 1'b0;
      stk_op    = '0;
      made_nxt  = made_r;
    end
  end

  // Slot counter and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      made_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      made_r <= made_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      out_slot_r   <= res_slot;
      out_rel_r    <= res_rel;
      out_used_r   <= made_nxt;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rsa_pkg::OUT_DATA_W - rsa_pkg::MADE_W - rsa_pkg::SLOT_W){1'b0}},
                       out_used_r, out_slot_r};
  assign out_tuser  = {out_status_r, out_rel_r};

endmodule

>>> hdl/rsa_checker.sv
module rsa_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rsa_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic [rsa_pkg::OUT_USER_W-1:0]    out_tuser
);

  // A result word held back keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A freed slot only comes with a good status.
  a_rel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == rsa_pkg::ST_OK)
    else $error("slot released on an error result");

  // Running out of slots means every slot has been made.
  a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == rsa_pkg::ST_EXHAUSTED |->
      out_tdata[12:6] == rsa_pkg::MADE_W'(rsa_pkg::SLOT_COUNT) && out_tdata[5:0] == '0)
    else $error("exhausted with slots still to make");

  // Using a dead value reports slot zero and frees nothing.
  a_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == rsa_pkg::ST_DEAD |->
      out_tdata[5:0] == '0 && !out_tuser[0])
    else $error("dead value result carries a slot");

endmodule

bind refcounted_slot_allocator_unit rsa_checker u_rsa_checker (.*);
